### src/tbea_pkg.sv
// Shared types, sizes and the quarter-wave sine table of the tone band energy analyser.
// No dependencies; every other file imports this package.
package tbea_pkg;

  localparam int MAX_BANDS    = 16;
  localparam int BAND_W       = $clog2(MAX_BANDS);
  localparam int MAX_SAMPLES  = 4096;
  localparam int CNT_W        = $clog2(MAX_SAMPLES) + 1;
  localparam int SIN_ENTRIES  = 1024;
  localparam int SIN_IDX_W    = $clog2(SIN_ENTRIES);
  localparam int QTR          = SIN_ENTRIES / 4;
  localparam int SAMPLE_W     = 16;
  localparam int LEVEL_W      = 16;
  localparam int SUM_W        = 44;
  localparam int SQ_W         = 42;
  localparam int PH_W         = 32;
  localparam int BC_W         = 5;
  localparam int MUL_W        = 33;
  localparam int OPND_W       = 64;
  localparam int DIV_W        = 50;
  localparam int ROOT_W       = 32;
  localparam int REM_W        = ROOT_W + 3;
  localparam int CM_W         = 31;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int BANDS_MIN    = 4;

  localparam logic [BC_W-1:0] NUM_BANDS_RST  = 5'd8;
  localparam logic [PH_W-1:0] BASE_STEP_RST  = 32'd8765239;
  localparam logic [PH_W-1:0] STEP_RATIO_RST = 32'd1019303113;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_BANDS  = 2'd0,
    REG_BASE_STEP  = 2'd1,
    REG_STEP_RATIO = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    KIND_AMP  = 1'b0,
    KIND_BAND = 1'b1
  } kind_t;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef logic signed [SAMPLE_W-1:0] qtab_t [QTR+1];

  // Q2.30 sine of a Q0.30 quarter-turn fraction, Taylor form nested.
  function automatic logic [63:0] quarter_sine(logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    t  = 64'd1073741824;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 110;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 72;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
    return (x * t) >> 30;
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t       tab;
    logic [63:0] v;
    for (int m = 0; m <= QTR; m++) begin
      v = (quarter_sine(64'(m) << (32 - SIN_IDX_W)) * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      tab[m] = SAMPLE_W'(v);
    end
    return tab;
  endfunction

  localparam qtab_t QSIN_TAB = build_qtab();

  // Full-turn Q1.15 sine from the quarter table by symmetry.
  function automatic logic signed [SAMPLE_W-1:0] sine_at(logic [SIN_IDX_W-1:0] idx);
    logic [SIN_IDX_W-2:0]        m;
    logic signed [SAMPLE_W-1:0]  v;
    m = idx[SIN_IDX_W-2] ? (SIN_IDX_W-1)'(QTR) - {1'b0, idx[SIN_IDX_W-3:0]}
                         : {1'b0, idx[SIN_IDX_W-3:0]};
    v = QSIN_TAB[m];
    return idx[SIN_IDX_W-1] ? -v : v;
  endfunction

endpackage

### src/tbea_if.sv
// Channel interfaces of the tone band energy analyser: samples, results, configuration.
// Depends on tbea_pkg.
interface tbea_in_if import tbea_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       end_of_buffer;
  modport source (output valid, sample, end_of_buffer, input ready);
  modport sink   (input valid, sample, end_of_buffer, output ready);
endinterface

interface tbea_out_if import tbea_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [BAND_W-1:0]  band_num;
  logic [LEVEL_W-1:0] level;
  logic               final_result;
  modport source (output valid, kind, band_num, level, final_result, input ready);
  modport sink   (input valid, kind, band_num, level, final_result, output ready);
endinterface

interface tbea_cfg_if import tbea_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/tbea_iter_unit.sv
// Bit-serial unit: restoring divide by the sample count, or integer square root.
// Depends on tbea_pkg.
module tbea_iter_unit import tbea_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  unit_req_t         req,
  input  logic [OPND_W-1:0] operand,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [OPND_W-1:0] result
);

  logic              busy_r;
  logic              done_r;
  unit_op_t          op_r;
  logic [5:0]        cnt_r;
  logic [OPND_W-1:0] acc_r;
  logic [REM_W-1:0]  rem_r;
  logic [OPND_W-1:0] quo_r;
  logic [CNT_W-1:0]  dvs_r;

  logic [CNT_W:0]   div_part;
  logic             div_ge;
  logic [CNT_W:0]   div_sub;
  logic [REM_W-1:0] sq_part;
  logic [REM_W-1:0] sq_trial;
  logic             sq_ge;

  assign div_part = {rem_r[CNT_W-1:0], acc_r[OPND_W-1]};
  assign div_ge   = div_part >= {1'b0, dvs_r};
  assign div_sub  = div_part - {1'b0, dvs_r};
  assign sq_part  = {rem_r[REM_W-3:0], acc_r[OPND_W-1 -: 2]};
  assign sq_trial = REM_W'({quo_r[ROOT_W-1:0], 2'b01});
  assign sq_ge    = sq_part >= sq_trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !req.start && busy_r && (cnt_r == 6'd1);
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        cnt_r  <= (req.op == OP_DIV) ? 6'(DIV_W) : 6'(ROOT_W);
        acc_r  <= (req.op == OP_DIV) ? {operand[DIV_W-1:0], {(OPND_W-DIV_W){1'b0}}} : operand;
        rem_r  <= '0;
        quo_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        if (op_r == OP_DIV) begin
          rem_r <= div_ge ? REM_W'(div_sub) : REM_W'(div_part);
          quo_r <= {quo_r[OPND_W-2:0], div_ge};
          acc_r <= acc_r << 1;
        end else begin
          rem_r <= sq_ge ? sq_part - sq_trial : sq_part;
          quo_r <= {quo_r[OPND_W-2:0], sq_ge};
          acc_r <= acc_r << 2;
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = quo_r;

endmodule

### src/tone_band_energy_analyzer_core.sv
// Top level of the tone band energy analyser: sequencer, shared multiplier, band state.
// Depends on tbea_pkg, tbea_if and tbea_iter_unit.
//
// Usage
//  in_if  : one signed Q1.15 sample per transaction; end_of_buffer closes the buffer.
//  out_if : results of a closed buffer: one amplitude result, then one band result
//           per band in use (bands in use clamped to 4..16); final_result marks the last.
//  cfg_if : register writes (0 bands in use, 1 base_phase_step, 2 band_step_ratio),
//           taken only while the block is idle; index 3 is ignored.
// Timing
//  A sample is finished before the next is taken: one 33x33 multiplier is shared for
//  the square and for the cosine and sine product of each of the 16 bands, two products per band.
//  Closing a buffer then computes the amplitude and one level per band in use on the
//  bit-serial divider and square root.
//  Writing the base step or ratio rebuilds the band step series.
// Reset
//  Registers return to their defaults, sums and phases clear, then the step series
//  is rebuilt before the first sample is taken.
// Stalls
//  Results sit in an output register; the next sample is taken while one waits,
//  but the sequencer holds when a further result is due and out_if.ready is low.
module tone_band_energy_analyzer_core import tbea_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  tbea_in_if.sink     in_if,
  tbea_out_if.source  out_if,
  tbea_cfg_if.sink    cfg_if
);

  typedef enum logic [4:0] {
    S_STEP0, S_STEPM, S_STEPW, S_IDLE, S_SQ, S_COS, S_SIN, S_FIN,
    S_AMPDIV, S_AMPSQ, S_BSTART, S_BCOS, S_BSIN, S_M1, S_M2, S_M3, S_BSQ,
    S_EMIT, S_CLR
  } state_t;

  typedef enum logic [1:0] {ACC_NONE, ACC_SQ, ACC_COS, ACC_SIN} acc_t;

  state_t state_r;

  // configuration
  logic [BC_W-1:0] bc_r;
  logic [PH_W-1:0] base_r;
  logic [PH_W-1:0] ratio_r;

  // buffer state
  logic signed [SUM_W-1:0] cos_r [MAX_BANDS];
  logic signed [SUM_W-1:0] sin_r [MAX_BANDS];
  logic [PH_W-1:0]         ph_r [MAX_BANDS];
  logic [PH_W-1:0]         step_r [MAX_BANDS];
  logic [SQ_W-1:0]         ss_r;
  logic [CNT_W-1:0]        seen_r;

  // working registers
  logic signed [SAMPLE_W-1:0] s_r;
  logic                       last_r;
  logic                       counted_r;
  logic [BAND_W-1:0]          band_r;
  logic [PH_W-1:0]            last_step_r;
  logic signed [2*MUL_W-1:0]  prod_r;
  acc_t                       acc_sel_r;
  acc_t                       acc_sel_nxt;
  logic [BAND_W-1:0]          acc_band_r;
  logic [CM_W-1:0]            cm_r;
  logic [CM_W-1:0]            sm_r;
  logic [OPND_W-1:0]          sumsq_r;
  logic [OPND_W-1:0]          operand_r;
  unit_req_t                  req_r;
  unit_req_t                  req_nxt;

  // pending and presented result
  kind_t              pend_kind_r;
  logic               pend_final_r;
  logic [LEVEL_W-1:0] pend_level_r;
  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [BAND_W-1:0]  out_band_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic               out_final_r;
  logic               emit_go;

  logic              u_done;
  logic [OPND_W-1:0] u_result;

  tbea_iter_unit u_iter (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req_r),
    .operand (operand_r),
    .divisor (seen_r),
    .done    (u_done),
    .result  (u_result)
  );

  // ---- combinational helpers ----
  logic [SIN_IDX_W-1:0]       sin_idx;
  logic [SIN_IDX_W-1:0]       cos_idx;
  logic signed [MUL_W-1:0]    ma;
  logic signed [MUL_W-1:0]    mb;
  logic [BAND_W-1:0]          last_band;
  logic [SUM_W-1:0]           cos_abs;
  logic [SUM_W-1:0]           sin_abs;
  logic [OPND_W-1:0]          step_sum;
  logic [ROOT_W+4:0]          mag18;
  logic [ROOT_W+4-14:0]       band_lvl;

  assign sin_idx = ph_r[band_r][PH_W-1 -: SIN_IDX_W];
  assign cos_idx = sin_idx + SIN_IDX_W'(QTR);
  assign cos_abs = cos_r[band_r][SUM_W-1] ? SUM_W'(-cos_r[band_r]) : SUM_W'(cos_r[band_r]);
  assign sin_abs = sin_r[band_r][SUM_W-1] ? SUM_W'(-sin_r[band_r]) : SUM_W'(sin_r[band_r]);
  // round(step * ratio / 2^29), wrapping as a 64-bit sum
  assign step_sum = OPND_W'(prod_r) + (OPND_W'(1) << 28);
  assign mag18    = ({5'b0, u_result[ROOT_W-1:0]} << 4) + ({5'b0, u_result[ROOT_W-1:0]} << 1);
  assign band_lvl = mag18[ROOT_W+4:14];

  // a result moves into the output register when the register is free or draining
  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || out_if.ready);

  always_comb begin
    if (bc_r < BC_W'(BANDS_MIN)) begin
      last_band = BAND_W'(BANDS_MIN - 1);
    end else if (bc_r > BC_W'(MAX_BANDS)) begin
      last_band = BAND_W'(MAX_BANDS - 1);
    end else begin
      last_band = BAND_W'(bc_r - BC_W'(1));
    end
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_SQ: begin
        ma = MUL_W'(s_r);
        mb = MUL_W'(s_r);
      end
      S_COS: begin
        ma = MUL_W'(s_r);
        mb = MUL_W'(sine_at(cos_idx));
      end
      S_SIN: begin
        ma = MUL_W'(s_r);
        mb = MUL_W'(sine_at(sin_idx));
      end
      S_STEPM: begin
        ma = $signed({1'b0, last_step_r});
        mb = $signed({1'b0, ratio_r});
      end
      S_M1: begin
        ma = $signed({2'b0, cm_r});
        mb = $signed({2'b0, cm_r});
      end
      S_M2: begin
        ma = $signed({2'b0, sm_r});
        mb = $signed({2'b0, sm_r});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // accumulator target for the product issued this cycle
  always_comb begin
    case (state_r)
      S_SQ:    acc_sel_nxt = ACC_SQ;
      S_COS:   acc_sel_nxt = ACC_COS;
      S_SIN:   acc_sel_nxt = ACC_SIN;
      default: acc_sel_nxt = ACC_NONE;
    endcase
  end

  // shared unit requests: divide by the count, then square root
  always_comb begin
    case (state_r)
      S_FIN:    req_nxt = '{start: last_r, op: OP_DIV};
      S_AMPDIV: req_nxt = '{start: u_done, op: OP_SQRT};
      S_BSTART: req_nxt = '{start: 1'b1, op: OP_DIV};
      S_BCOS:   req_nxt = '{start: u_done, op: OP_DIV};
      S_M3:     req_nxt = '{start: 1'b1, op: OP_SQRT};
      default:  req_nxt = '{start: 1'b0, op: OP_DIV};
    endcase
  end

  assign in_if.ready = (state_r == S_IDLE) && !cfg_if.valid;
  assign cfg_if.ready = (state_r == S_IDLE);

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_STEP0;
      bc_r        <= NUM_BANDS_RST;
      base_r      <= BASE_STEP_RST;
      ratio_r     <= STEP_RATIO_RST;
      ss_r        <= '0;
      seen_r      <= '0;
      acc_sel_r   <= ACC_NONE;
      req_r       <= '0;
      out_valid_r <= 1'b0;
      band_r      <= '0;
      for (int k = 0; k < MAX_BANDS; k++) begin
        cos_r[k] <= '0;
        sin_r[k] <= '0;
        ph_r[k]  <= '0;
      end
    end else begin
      prod_r      <= ma * mb;
      acc_sel_r   <= acc_sel_nxt;
      acc_band_r  <= band_r;
      req_r       <= req_nxt;
      out_valid_r <= emit_go || (out_valid_r && !out_if.ready);

      // accumulate the registered product issued in the previous cycle
      case (acc_sel_r)
        ACC_SQ:  ss_r <= ss_r + prod_r[SQ_W-1:0];
        ACC_COS: cos_r[acc_band_r] <= cos_r[acc_band_r] + SUM_W'(prod_r);
        ACC_SIN: sin_r[acc_band_r] <= sin_r[acc_band_r] + SUM_W'(prod_r);
        default: ;
      endcase

      case (state_r)
        S_STEP0: begin
          step_r[0]   <= base_r;
          last_step_r <= base_r;
          band_r      <= BAND_W'(1);
          state_r     <= S_STEPM;
        end
        S_STEPM: state_r <= S_STEPW;
        S_STEPW: begin
          step_r[band_r] <= step_sum[PH_W+28:29];
          last_step_r    <= step_sum[PH_W+28:29];
          if (band_r == BAND_W'(MAX_BANDS - 1)) begin
            band_r  <= '0;
            state_r <= S_IDLE;
          end else begin
            band_r  <= band_r + BAND_W'(1);
            state_r <= S_STEPM;
          end
        end
        S_IDLE: begin
          if (cfg_if.valid) begin
            case (cfg_if.index)
              REG_NUM_BANDS: bc_r <= cfg_if.data[BC_W-1:0];
              REG_BASE_STEP: begin
                base_r  <= cfg_if.data;
                state_r <= S_STEP0;
              end
              REG_STEP_RATIO: begin
                ratio_r <= cfg_if.data;
                state_r <= S_STEP0;
              end
              default: ;
            endcase
          end else if (in_if.valid) begin
            s_r       <= in_if.sample;
            last_r    <= in_if.end_of_buffer;
            band_r    <= '0;
            counted_r <= seen_r < CNT_W'(MAX_SAMPLES);
            state_r   <= (seen_r < CNT_W'(MAX_SAMPLES)) ? S_SQ : S_FIN;
          end
        end
        S_SQ: begin
          state_r <= S_COS;
        end
        S_COS: begin
          state_r <= S_SIN;
        end
        S_SIN: begin
          ph_r[band_r]   <= ph_r[band_r] + step_r[band_r];
          if (band_r == BAND_W'(MAX_BANDS - 1)) begin
            state_r <= S_FIN;
          end else begin
            band_r  <= band_r + BAND_W'(1);
            state_r <= S_COS;
          end
        end
        S_FIN: begin
          if (counted_r) begin
            seen_r <= seen_r + CNT_W'(1);
          end
          if (last_r) begin
            // 144 * square_sum as shift and add
            operand_r <= OPND_W'((DIV_W'(ss_r) << 7) + (DIV_W'(ss_r) << 4));
            state_r   <= S_AMPDIV;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_AMPDIV: begin
          if (u_done) begin
            operand_r <= u_result;
            state_r   <= S_AMPSQ;
          end
        end
        S_AMPSQ: begin
          if (u_done) begin
            pend_level_r <= (u_result > OPND_W'(16'hFFFF)) ? 16'hFFFF
                                                          : u_result[LEVEL_W-1:0];
            pend_kind_r  <= KIND_AMP;
            pend_final_r <= 1'b0;
            band_r       <= '0;
            state_r      <= S_EMIT;
          end
        end
        S_BSTART: begin
          operand_r <= OPND_W'(cos_abs);
          state_r   <= S_BCOS;
        end
        S_BCOS: begin
          if (u_done) begin
            cm_r      <= u_result[CM_W-1:0];
            operand_r <= OPND_W'(sin_abs);
            state_r   <= S_BSIN;
          end
        end
        S_BSIN: begin
          if (u_done) begin
            sm_r    <= u_result[CM_W-1:0];
            state_r <= S_M1;
          end
        end
        S_M1: state_r <= S_M2;
        S_M2: begin
          sumsq_r <= OPND_W'(prod_r);
          state_r <= S_M3;
        end
        S_M3: begin
          operand_r <= sumsq_r + OPND_W'(prod_r);
          state_r   <= S_BSQ;
        end
        S_BSQ: begin
          if (u_done) begin
            pend_level_r <= (band_lvl > 23'(16'hFFFF)) ? 16'hFFFF : band_lvl[LEVEL_W-1:0];
            pend_kind_r  <= KIND_BAND;
            pend_final_r <= (band_r == last_band);
            state_r      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_kind_r  <= pend_kind_r;
            out_band_r  <= (pend_kind_r == KIND_AMP) ? '0 : band_r;
            out_level_r <= pend_level_r;
            out_final_r <= pend_final_r;
            if (pend_final_r) begin
              state_r <= S_CLR;
            end else begin
              if (pend_kind_r == KIND_BAND) begin
                band_r <= band_r + BAND_W'(1);
              end
              state_r <= S_BSTART;
            end
          end
        end
        S_CLR: begin
          ss_r   <= '0;
          seen_r <= '0;
          band_r <= '0;
          for (int k = 0; k < MAX_BANDS; k++) begin
            cos_r[k] <= '0;
            sin_r[k] <= '0;
            ph_r[k]  <= '0;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.kind         = out_kind_r;
  assign out_if.band_num     = out_band_r;
  assign out_if.level        = out_level_r;
  assign out_if.final_result = out_final_r;

endmodule
